### design/ljpf_pkg.sv
// Shared types, constants, stage map and divider step for the Lennard-Jones pair force core.
package ljpf_pkg;

  localparam int POS_W   = 24;
  localparam int CFG_W   = 24;
  localparam int OUT_W   = 32;
  localparam int SQ_W    = 48;
  localparam int R2_W    = 50;
  localparam int Q_BITS  = 41;
  localparam int Q_FRAC  = 32;
  localparam int F_BITS  = 32;
  localparam int MUL_LAT = 3;
  localparam int MUL_CW  = 32;

  // Register stage numbers along the pipeline.
  localparam int S_R2   = 4;
  localparam int S_QD   = S_R2 + 1;
  localparam int S_Q    = S_QD + Q_BITS;
  localparam int S_QQ   = S_Q + MUL_LAT;
  localparam int S_Q3   = S_QQ + MUL_LAT;
  localparam int S_H    = S_Q3 + 1;
  localparam int S_HM   = S_H + MUL_LAT;
  localparam int S_PF   = S_HM + MUL_LAT;
  localparam int S_FD   = S_PF + 1;
  localparam int S_LAST = S_FD + F_BITS;

  typedef enum logic [2:0] {
    CFG_BOX_X   = 3'd0,
    CFG_BOX_Y   = 3'd1,
    CFG_BOX_Z   = 3'd2,
    CFG_SIGMA   = 3'd3,
    CFG_EPSILON = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] BOX_RST   = 24'd5242880;
  localparam logic [CFG_W-1:0] SIGMA_RST = 24'd65536;
  localparam logic [CFG_W-1:0] EPS_RST   = 24'd65536;

  localparam logic [63:0]      ONE_Q32 = 64'h1_0000_0000;
  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [2:0][POS_W-1:0] ad;
    logic [2:0]            dneg;
    logic [2:0]            dpos;
    logic [R2_W-1:0]       r2;
    logic                  coin;
    logic                  close;
    logic                  above;
    logic                  rep;
    logic [OUT_W-1:0]      eval;
    logic                  esat;
  } ctl_t;

  typedef struct packed {
    logic [2:0][OUT_W-1:0] frc;
    logic [OUT_W-1:0]      energy;
    logic                  sat;
    logic                  coin;
  } res_t;

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [R2_W:0] div_step(logic [R2_W-1:0] rem, logic bin,
                                             logic [R2_W-1:0] d);
    logic [R2_W:0] t;
    logic [R2_W:0] diff;
    logic [R2_W:0] r;
    t    = {rem, bin};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r = {1'b1, diff[R2_W-1:0]};
    end else begin
      r = {1'b0, t[R2_W-1:0]};
    end
    return r;
  endfunction

endpackage

### design/lennard_jones_pair_force_core.sv
// Top level of the Lennard-Jones pair force core with minimum-image wrap.
//
//  Channel | Direction | Payload
//  in_     | slave     | tdata: a_x, a_y, a_z, b_x, b_y, b_z (24 bits each)
//  out_    | master    | tdata: force_x, force_y, force_z, energy; tuser: coincident, saturated
//  cfg_    | slave     | addr: register index; data: 24-bit register value
//
// One word is taken per cycle while the skid register is empty.
// The pipe contains the 41-stage quotient divider for sigma^2/r^2 and the
// 32-stage force dividers, one bit per stage, with the multipliers in between.
// Reset is synchronous and active low; it clears valid bits and restores the registers.
// When the output stalls, a skid register catches one result and the whole pipe then
// holds; in_tready depends only on that skid register.
module lennard_jones_pair_force_core
  import ljpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // force_x, force_y, force_z, energy
  output logic [1:0]   out_tuser,  // coincident, saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_data
);

  localparam int H_W = 59;

  logic [CFG_W-1:0] box_r [3];
  logic [CFG_W-1:0] sigma_r;
  logic [CFG_W-1:0] eps_r;
  logic [SQ_W-1:0]  sig2_r;
  logic [28:0]      eps24_r;
  logic [25:0]      eps4_r;

  logic             en;
  logic             in_acc;
  logic [S_LAST:1]  v_r;

  logic signed [POS_W:0] dr_r [3];
  logic [POS_W-1:0]      ad2_r [3];
  logic [2:0]            dneg2_r, dpos2_r;
  logic [SQ_W-1:0]       sq3_r [3];
  logic [POS_W-1:0]      ad3_r [3];
  logic [2:0]            dneg3_r, dpos3_r;
  logic [R2_W-1:0]       r2_r;
  logic [POS_W-1:0]      ad4_r [3];
  logic [2:0]            dneg4_r, dpos4_r;

  ctl_t ctl_r [S_QD:S_LAST];

  logic [R2_W-1:0]   qrem_r [Q_BITS];
  logic [Q_BITS-1:0] qquo_r [Q_BITS+1];
  logic [Q_BITS-1:0] qd_r [MUL_LAT];

  logic [2*Q_BITS-1:0] qq_p;
  logic [3*Q_BITS-1:0] q3_p;
  logic [H_W-1:0]      h_c, habs_c;
  logic [H_W:0]        twoh_c, m_c;
  logic                above_c, rep_c;
  logic [H_W-1:0]      h_r, habs_r;
  logic [H_W:0]        m_r;
  logic [2*H_W:0]      hm_p;
  logic [2*H_W-1:0]    he_p;
  logic [52:0]         e24ad_r [3];
  logic [2*H_W+25:0]   eng_p;
  logic [79:0]         emag_c;
  logic [OUT_W-1:0]    eval_c;
  logic                esat_c;

  logic [R2_W-1:0]   frem_r [3][F_BITS];
  logic [F_BITS-1:0] flo_r  [3][F_BITS];
  logic [F_BITS-1:0] fquo_r [3][F_BITS+1];
  logic              fovf_r [3][F_BITS+1];

  res_t res_c;
  res_t out_d_r, skid_d_r;
  logic out_v_r, skid_v_r;
  logic push, pop;

  // Configuration registers and the constants derived from them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= BOX_RST;
      box_r[1] <= BOX_RST;
      box_r[2] <= BOX_RST;
      sigma_r  <= SIGMA_RST;
      eps_r    <= EPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_BOX_X:   box_r[0] <= cfg_data;
        CFG_BOX_Y:   box_r[1] <= cfg_data;
        CFG_BOX_Z:   box_r[2] <= cfg_data;
        CFG_SIGMA:   sigma_r  <= cfg_data;
        CFG_EPSILON: eps_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sig2_r  <= sigma_r * sigma_r;
    eps24_r <= (29'(eps_r) << 4) + (29'(eps_r) << 3);
    eps4_r  <= {eps_r, 2'b00};
  end

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[S_LAST-1:1], in_acc};
    end
  end

  // Front end: displacement, wrap, squares, squared distance.
  always_ff @(posedge clk) begin
    logic signed [POS_W+1:0] d26;
    logic signed [POS_W+1:0] d2;
    logic signed [POS_W+1:0] bs;
    logic signed [POS_W+1:0] dw;
    logic [POS_W:0]          dn;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dr_r[k] <= $signed({1'b0, in_tdata[(k+3)*POS_W +: POS_W]})
                 - $signed({1'b0, in_tdata[k*POS_W +: POS_W]});
      end
      for (int k = 0; k < 3; k++) begin
        d26 = {dr_r[k][POS_W], dr_r[k]};
        d2  = {dr_r[k], 1'b0};
        bs  = $signed({2'b00, box_r[k]});
        if (d2 < -bs) begin
          dw = d26 + bs;
        end else if (d2 > bs) begin
          dw = d26 - bs;
        end else begin
          dw = d26;
        end
        dn = -dw[POS_W:0];
        ad2_r[k]   <= dw[POS_W] ? dn[POS_W-1:0] : dw[POS_W-1:0];
        dneg2_r[k] <= dw[POS_W];
        dpos2_r[k] <= !dw[POS_W] && (dw[POS_W:0] != '0);
      end
      for (int k = 0; k < 3; k++) begin
        sq3_r[k] <= ad2_r[k] * ad2_r[k];
        ad3_r[k] <= ad2_r[k];
      end
      dneg3_r <= dneg2_r;
      dpos3_r <= dpos2_r;
      r2_r    <= R2_W'(sq3_r[0]) + R2_W'(sq3_r[1]) + R2_W'(sq3_r[2]);
      ad4_r   <= ad3_r;
      dneg4_r <= dneg3_r;
      dpos4_r <= dpos3_r;
    end
  end

  // Stage where the control word is formed and the quotient divider starts.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ctl_r[S_QD].ad[k] <= ad4_r[k];
      end
      ctl_r[S_QD].dneg  <= dneg4_r;
      ctl_r[S_QD].dpos  <= dpos4_r;
      ctl_r[S_QD].r2    <= r2_r;
      ctl_r[S_QD].coin  <= (r2_r == '0);
      // The pair is too close when sigma^2 / r2 reaches 512.
      ctl_r[S_QD].close <= ({11'd0, sig2_r} >= {r2_r, 9'd0});
      ctl_r[S_QD].above <= 1'b0;
      ctl_r[S_QD].rep   <= 1'b0;
      ctl_r[S_QD].eval  <= '0;
      ctl_r[S_QD].esat  <= 1'b0;
      qrem_r[0] <= R2_W'(sig2_r[SQ_W-1:Q_BITS-Q_FRAC]);
      qquo_r[0] <= '0;
    end
  end

  for (genvar s = S_QD + 1; s <= S_LAST; s++) begin : g_ctl
    if (s == S_H) begin : g_h
      always_ff @(posedge clk) begin
        ctl_t c;
        if (en) begin
          c        = ctl_r[s-1];
          c.above  = above_c;
          c.rep    = rep_c;
          ctl_r[s] <= c;
        end
      end
    end else if (s == S_FD) begin : g_e
      always_ff @(posedge clk) begin
        ctl_t c;
        if (en) begin
          c        = ctl_r[s-1];
          c.eval   = eval_c;
          c.esat   = esat_c;
          ctl_r[s] <= c;
        end
      end
    end else begin : g_p
      always_ff @(posedge clk) begin
        if (en) begin
          ctl_r[s] <= ctl_r[s-1];
        end
      end
    end
  end

  // Quotient q = sigma^2 * 2^32 / r2, one bit per stage.
  for (genvar j = 1; j <= Q_BITS; j++) begin : g_qd
    localparam int BI = Q_BITS - j;
    logic          bin;
    logic [R2_W:0] st;
    if (BI >= Q_FRAC) begin : g_b
      assign bin = sig2_r[BI-Q_FRAC];
    end else begin : g_z
      assign bin = 1'b0;
    end
    assign st = div_step(qrem_r[j-1], bin, ctl_r[S_QD+j-1].r2);
    always_ff @(posedge clk) begin
      if (en) begin
        qquo_r[j] <= {qquo_r[j-1][Q_BITS-2:0], st[R2_W]};
      end
    end
    if (j < Q_BITS) begin : g_r
      always_ff @(posedge clk) begin
        if (en) begin
          qrem_r[j] <= st[R2_W-1:0];
        end
      end
    end
  end

  // h = q^3 / 2^64.
  ljpf_mul #(.AW(Q_BITS), .BW(Q_BITS)) u_qq (
    .clk(clk), .en(en), .a(qquo_r[Q_BITS]), .b(qquo_r[Q_BITS]), .p(qq_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r[0] <= qquo_r[Q_BITS];
      for (int i = 1; i < MUL_LAT; i++) begin
        qd_r[i] <= qd_r[i-1];
      end
    end
  end

  ljpf_mul #(.AW(2*Q_BITS), .BW(Q_BITS)) u_q3 (
    .clk(clk), .en(en), .a(qq_p), .b(qd_r[MUL_LAT-1]), .p(q3_p)
  );

  always_comb begin
    h_c     = q3_p[64 +: H_W];
    above_c = (h_c >= H_W'(ONE_Q32));
    habs_c  = above_c ? h_c - H_W'(ONE_Q32) : H_W'(ONE_Q32) - h_c;
    twoh_c  = {h_c, 1'b0};
    rep_c   = (twoh_c >= (H_W+1)'(ONE_Q32));
    m_c     = rep_c ? twoh_c - (H_W+1)'(ONE_Q32) : (H_W+1)'(ONE_Q32) - twoh_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r    <= h_c;
      habs_r <= habs_c;
      m_r    <= m_c;
    end
  end

  ljpf_mul #(.AW(H_W), .BW(H_W+1)) u_hm (
    .clk(clk), .en(en), .a(h_r), .b(m_r), .p(hm_p)
  );

  ljpf_mul #(.AW(H_W), .BW(H_W)) u_he (
    .clk(clk), .en(en), .a(h_r), .b(habs_r), .p(he_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e24ad_r[k] <= ctl_r[S_HM-1].ad[k] * eps24_r;
      end
    end
  end

  // Energy magnitude 4*eps*h*|h-1| / 2^64, clamped toward the sign of h - 1.
  ljpf_mul #(.AW(2*H_W), .BW(26)) u_eng (
    .clk(clk), .en(en), .a(he_p), .b(eps4_r), .p(eng_p)
  );

  always_comb begin
    emag_c = eng_p[64 +: 80];
    if (ctl_r[S_PF].above) begin
      esat_c = (emag_c[79:31] != '0);
      eval_c = esat_c ? SAT_POS : emag_c[OUT_W-1:0];
    end else begin
      esat_c = (emag_c > 80'(SAT_NEG));
      eval_c = esat_c ? SAT_NEG : -emag_c[OUT_W-1:0];
    end
  end

  // Force magnitude per axis: (24*eps*|d|) * h * m / (2^48 * r2), one bit per stage.
  for (genvar k = 0; k < 3; k++) begin : g_ax
    logic [2*H_W+53:0] pf_p;
    logic [123:0]      nf;
    ljpf_mul #(.AW(2*H_W+1), .BW(53)) u_pf (
      .clk(clk), .en(en), .a(hm_p), .b(e24ad_r[k]), .p(pf_p)
    );
    assign nf = pf_p[171:48];
    always_ff @(posedge clk) begin
      if (en) begin
        frem_r[k][0] <= nf[R2_W+F_BITS-1:F_BITS];
        flo_r[k][0]  <= nf[F_BITS-1:0];
        fquo_r[k][0] <= '0;
        // Quotients of 2^32 and more saturate whatever the sign.
        fovf_r[k][0] <= (nf[123:F_BITS] >= 92'(ctl_r[S_PF].r2));
      end
    end
    for (genvar j = 1; j <= F_BITS; j++) begin : g_st
      logic [R2_W:0] st;
      assign st = div_step(frem_r[k][j-1], flo_r[k][j-1][F_BITS-j], ctl_r[S_FD+j-1].r2);
      always_ff @(posedge clk) begin
        if (en) begin
          fquo_r[k][j] <= {fquo_r[k][j-1][F_BITS-2:0], st[R2_W]};
          fovf_r[k][j] <= fovf_r[k][j-1];
        end
      end
      if (j < F_BITS) begin : g_r
        always_ff @(posedge clk) begin
          if (en) begin
            frem_r[k][j] <= st[R2_W-1:0];
            flo_r[k][j]  <= flo_r[k][j-1];
          end
        end
      end
    end
  end

  // Result assembly from the last stage.
  always_comb begin
    logic             fpos;
    logic             fsat;
    logic [OUT_W-1:0] fq;
    res_c = '0;
    fpos  = 1'b0;
    fsat  = 1'b0;
    fq    = '0;
    if (ctl_r[S_LAST].coin) begin
      res_c.coin = 1'b1;
    end else if (ctl_r[S_LAST].close) begin
      res_c.energy = SAT_POS;
      res_c.sat    = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (ctl_r[S_LAST].dpos[k]) begin
          res_c.frc[k] = SAT_NEG;
        end else if (ctl_r[S_LAST].dneg[k]) begin
          res_c.frc[k] = SAT_POS;
        end
      end
    end else begin
      res_c.energy = ctl_r[S_LAST].eval;
      res_c.sat    = ctl_r[S_LAST].esat;
      for (int k = 0; k < 3; k++) begin
        fq   = fquo_r[k][F_BITS];
        fpos = ctl_r[S_LAST].rep != ctl_r[S_LAST].dpos[k];
        if (fpos) begin
          fsat         = fovf_r[k][F_BITS] || fq[OUT_W-1];
          res_c.frc[k] = fsat ? SAT_POS : fq;
        end else begin
          fsat         = fovf_r[k][F_BITS] || (fq > SAT_NEG);
          res_c.frc[k] = fsat ? SAT_NEG : -fq;
        end
        res_c.sat = res_c.sat || fsat;
      end
    end
  end

  // Output register with one skid entry behind it.
  assign push = en && v_r[S_LAST];
  assign pop  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_d_r <= res_c;
      end else begin
        out_d_r <= res_c;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_d_r.energy, out_d_r.frc[2], out_d_r.frc[1], out_d_r.frc[0]};
  assign out_tuser  = {out_d_r.sat, out_d_r.coin};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_v_r && !out_tready) |=> skid_v_r)
    else $error("result leaving the pipe was not caught by the skid entry");

  a_coin_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (!out_tuser[1] && out_tdata == '0))
    else $error("coincident result carries nonzero data or saturation");

endmodule

### design/ljpf_mul.sv
// Unsigned wide multiplier built from registered 32 by 32 partial products, three stages.
module ljpf_mul
  import ljpf_pkg::*;
#(
  parameter int AW = 41,
  parameter int BW = 41
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int CW = MUL_CW;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int RW = CW * (NB + 1);
  localparam int TW = CW * (NA + NB);

  logic [NA*CW-1:0] ax;
  logic [NB*CW-1:0] bx;
  logic [2*CW-1:0]  pp_r [NA][NB];
  logic [RW-1:0]    row_c [NA];
  logic [RW-1:0]    row_r [NA];
  logic [TW-1:0]    sum_c;
  logic [AW+BW-1:0] p_r;

  assign ax = (NA*CW)'(a);
  assign bx = (NB*CW)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ax[i*CW +: CW] * bx[j*CW +: CW];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_c[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_c[i] = row_c[i] + (RW'(pp_r[i][j]) << (CW * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_c;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NA; i++) begin
      sum_c = sum_c + (TW'(row_r[i]) << (CW * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum_c[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule

### test/tb_lennard_jones_pair_force_core.sv
// Self-checking testbench for the Lennard-Jones pair force core with minimum-image wrap.
`timescale 1ns / 1ps

module tb_lennard_jones_pair_force_core;
  import ljpf_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] frc;
    logic [31:0]      energy;
    logic             coin;
    logic             sat;
  } pair_result_t;

  class pair_force_scoreboard;
    logic [23:0]  box [3];
    logic [23:0]  sigma_q;
    logic [23:0]  eps_q;
    pair_result_t pending [$];
    int           mismatches;

    function new();
      box[0] = BOX_RST;
      box[1] = BOX_RST;
      box[2] = BOX_RST;
      sigma_q = SIGMA_RST;
      eps_q = EPS_RST;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [23:0] v);
      case (idx)
        CFG_BOX_X:   box[0] = v;
        CFG_BOX_Y:   box[1] = v;
        CFG_BOX_Z:   box[2] = v;
        CFG_SIGMA:   sigma_q = v;
        CFG_EPSILON: eps_q = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp(bit positive, longint unsigned mag, ref bit sat);
      if (positive) begin
        if (mag > 64'h7FFF_FFFF) begin
          sat = 1;
          mag = 64'h7FFF_FFFF;
        end
        return mag[31:0];
      end else begin
        if (mag > 64'h8000_0000) begin
          sat = 1;
          mag = 64'h8000_0000;
        end
        return 32'(-mag);
      end
    endfunction

    // Works out the force and energy of one pair and queues the expectation.
    function void note_pair(logic [143:0] p);
      longint d [3];
      longint bx;
      longint unsigned r2, q, h, mag, m, ad;
      logic [255:0] n;
      bit sat, above, repulse;
      pair_result_t e;
      e = '0;
      r2 = 0;
      sat = 0;
      for (int k = 0; k < 3; k++) begin
        bx = longint'(box[k]);
        d[k] = longint'(p[(k+3)*24 +: 24]) - longint'(p[k*24 +: 24]);
        if (2 * d[k] < -bx) d[k] += bx;
        else if (2 * d[k] > bx) d[k] -= bx;
        r2 += longint'(d[k] * d[k]);
      end
      if (r2 == 0) begin
        e.coin = 1;
        pending.push_back(e);
        return;
      end
      n = (256'(sigma_q) * sigma_q) << 32;
      n = n / r2;
      if (n >= 256'(1) << 41) begin
        // Very close pair: energy and every nonzero force component pinned at the rails.
        for (int k = 0; k < 3; k++)
          e.frc[k] = d[k] > 0 ? SAT_NEG : (d[k] < 0 ? SAT_POS : 32'd0);
        e.energy = SAT_POS;
        e.sat = 1;
        pending.push_back(e);
        return;
      end
      q = n[63:0];
      n = (256'(q) * q * q) >> 64;
      h = (n > 256'(1) << 62) ? 64'd1 << 62 : n[63:0];
      above = h >= ONE_Q32;
      n = (256'(4 * eps_q) * h * (above ? h - ONE_Q32 : ONE_Q32 - h)) >> 64;
      mag = (n > 256'(1) << 33) ? 64'd1 << 33 : n[63:0];
      e.energy = clamp(above, mag, sat);
      repulse = 2 * h >= ONE_Q32;
      m = repulse ? 2 * h - ONE_Q32 : ONE_Q32 - 2 * h;
      for (int k = 0; k < 3; k++) begin
        if (d[k] != 0) begin
          ad = d[k] < 0 ? -d[k] : d[k];
          n = (256'(24 * eps_q) * h * m * ad) >> 48;
          n = n / r2;
          mag = (n > 256'(1) << 33) ? 64'd1 << 33 : n[63:0];
          e.frc[k] = clamp(repulse != (d[k] > 0), mag, sat);
        end
      end
      e.sat = sat;
      pending.push_back(e);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
    endfunction

    function void check_result(logic [127:0] data, logic [1:0] user);
      pair_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, data[31:0]);
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 3; k++)
        if (data[k*32 +: 32] !== e.frc[k]) report($sformatf("force[%0d]", k), e.frc[k],
                                                  data[k*32 +: 32]);
      if (data[127:96] !== e.energy) report("energy", e.energy, data[127:96]);
      if (user[0] !== e.coin) report("coincident", e.coin, user[0]);
      if (user[1] !== e.sat) report("saturated", e.sat, user[1]);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;  // a_x, a_y, a_z, b_x, b_y, b_z
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;      // force_x, force_y, force_z, energy
  logic [1:0]   out_tuser;      // coincident, saturated
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_addr = '0;
  logic [23:0]  cfg_data = '0;

  pair_force_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;

  lennard_jones_pair_force_core u_top (.*);

  always #10 clk = ~clk;

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_pair(logic [143:0] p);
    in_tdata <= p;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_pair(p);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
    cfg_addr <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic set_all(logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                         logic [23:0] sg, logic [23:0] ep);
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_BOX_Z, bz);
    write_reg(CFG_SIGMA, sg);
    write_reg(CFG_EPSILON, ep);
  endtask

  function automatic logic [143:0] make_pair(logic [23:0] a [3], int off [3]);
    logic [143:0] p;
    for (int k = 0; k < 3; k++) begin
      p[k*24 +: 24] = a[k];
      p[(k+3)*24 +: 24] = 24'(int'(a[k]) + off[k]);
    end
    return p;
  endfunction

  // Mostly pairs at a few sigma apart, with some coincident and fully random ones.
  function automatic logic [143:0] random_pair();
    logic [23:0] a [3];
    int off [3];
    int span, sel;
    sel = $urandom_range(0, 9);
    span = int'(sb.sigma_q) * 2;
    for (int k = 0; k < 3; k++) begin
      a[k] = 24'($urandom);
      off[k] = sel == 1 ? 0 : $urandom_range(0, 2 * span) - span;
    end
    if (sel == 0) return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    return make_pair(a, off);
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_pair(random_pair());
    drain();
  endtask

  initial begin
    logic [23:0] a [3];
    int off [3];
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed pairs under the reset settings.
    a = '{24'd1000, 24'd2000, 24'd3000};
    off = '{0, 0, 0};        send_pair(make_pair(a, off));   // coincident
    send_pair('0);
    send_pair('1);
    off = '{1, 0, 0};        send_pair(make_pair(a, off));   // very close
    off = '{65536, 0, 0};    send_pair(make_pair(a, off));   // r equals sigma
    off = '{0, -65536, 0};   send_pair(make_pair(a, off));
    off = '{0, 0, 73562};    send_pair(make_pair(a, off));   // near the minimum
    off = '{-80000, 70000, -60000}; send_pair(make_pair(a, off));
    off = '{500000, -300000, 200000}; send_pair(make_pair(a, off)); // weak attraction
    send_pair({72'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
    send_pair({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 72'h0});
    send_pair({24'd5242880, 24'd2621441, 24'd0, 24'd0, 24'd0, 24'd2621440}); // wrap edges
    a = '{24'd0, 24'd0, 24'd0};
    off = '{30000, -30000, 10};   send_pair(make_pair(a, off));
    drain();

    hold_req = 1;
    random_phase(90);

    set_all(24'd1, 24'd1, 24'd1, 24'hFFFFFF, 24'hFFFFFF);
    random_phase(50);
    set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1);
    random_phase(50);
    set_all(24'd655360, 24'd393216, 24'd1048576, 24'd131072, 24'd32768);
    random_phase(90);
    set_all(24'($urandom_range(65536, 16777215)), 24'($urandom_range(65536, 16777215)),
            24'($urandom_range(65536, 16777215)), 24'($urandom_range(16384, 262144)),
            24'($urandom_range(1, 16777215)));
    random_phase(80);
    calm = 1;
    random_phase(80);

    repeat (200) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/ljpf_pkg.sv
design/ljpf_mul.sv
design/lennard_jones_pair_force_core.sv
test/tb_lennard_jones_pair_force_core.sv
